### hdl/bdel_pkg.sv
// ============================================================================
// Bounded double-ended list: shared types
// Operation and status codes, the transfer payloads of both channels, and the
// control group that the top level broadcasts to every storage cell.
// ============================================================================
`default_nettype none

package bdel_pkg;

    // Operation codes carried by one input transfer.
    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_REM_HEAD = 3'd2,
        OP_REM_TAIL = 3'd3,
        OP_RD_HEAD  = 3'd4,
        OP_RD_TAIL  = 3'd5,
        OP_RD_INDEX = 3'd6,
        OP_CLEAR    = 3'd7
    } t_op;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Input transfer payload.
    typedef struct packed {
        t_op         operation;
        logic [31:0] entry_data;
        logic [5:0]  element_index;
    } t_in_item;

    // Output transfer payload.
    typedef struct packed {
        logic [31:0] read_data;
        logic [6:0]  entry_count;
        t_status     status;
    } t_out_item;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;    // every cell takes its lower neighbor's word
        logic shift_down;  // every cell takes its upper neighbor's word
        logic write_tail;  // the cell at the tail position takes the new word
        logic read_en;     // the cell at the read position shows its word
    } t_cell_ctrl;

endpackage

`default_nettype wire

### hdl/bdel_cell.sv
// ============================================================================
// Bounded double-ended list: storage cell
// Holds one entry word. Each cycle it keeps its word, takes the word of a
// neighbor, or takes the new word, and it drives its word onto the read
// bus when its position is the one being read.
// ============================================================================
`default_nettype none

module bdel_cell
    import bdel_pkg::*;
#(
    parameter int unsigned POS_W   = 6,
    parameter int unsigned WORD_W  = 32,
    parameter int unsigned CELL_ID = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [POS_W-1:0]  i_tail_pos,
    input  wire logic [POS_W-1:0]  i_rd_pos,
    input  wire logic [WORD_W-1:0] i_new_word,
    input  wire logic [WORD_W-1:0] i_lower_word,
    input  wire logic [WORD_W-1:0] i_upper_word,
    output logic      [WORD_W-1:0] o_word,
    output logic      [WORD_W-1:0] o_rd_word
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_ID);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // Select the next content of this cell.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.shift_up) begin
            n_word = i_lower_word;
        end else if (i_ctrl.shift_down) begin
            n_word = i_upper_word;
        end else if (i_ctrl.write_tail && (i_tail_pos == MY_POS)) begin
            n_word = i_new_word;
        end
    end

    // Payload storage; no reset needed.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Neighbor hand-off and gated read contribution.
    assign o_word    = r_word;
    assign o_rd_word = (i_ctrl.read_en && (i_rd_pos == MY_POS)) ? r_word : '0;

endmodule

`default_nettype wire

### hdl/bounded_double_ended_list_unit.sv
// ============================================================================
// Bounded double-ended list unit
// Fixed-capacity ordered list built as a chain of storage cells. Inserts and
// removes at the head shift the whole chain by one place; tail inserts and
// reads touch one cell and tail removes none. Each input transfer returns one
// result with the word read, the entry count and a status code.
// ============================================================================
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One operation per cycle unless stalled; its result appears in the output
// register on the next cycle. The chain shift and the count update both
// complete in the accepting cycle, so a following operation may be accepted
// right after. The input is stalled only while a result is held and the output
// is stalled. Reset clears the entry count and the output register valid; cell
// contents are left as they are and are never read before being written.
// ============================================================================
`default_nettype none

module bounded_double_ended_list_unit
    import bdel_pkg::*;
#(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned ENTRY_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // Control state and output register.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    t_cell_ctrl       cell_ctrl;
    logic [POS_W-1:0] tail_pos;
    logic [POS_W-1:0] rd_pos;
    t_status          status;
    logic [ENTRY_WIDTH-1:0] new_word;
    logic [ENTRY_WIDTH-1:0] rd_acc;

    logic [ENTRY_WIDTH-1:0] cell_word [CAPACITY];
    logic [ENTRY_WIDTH-1:0] cell_rd   [CAPACITY];

    // Handshake: the output register parts the two sides.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign idx_ext  = CMP_W'(i_in_item.element_index);
    assign cnt_ext  = CMP_W'(r_count);
    assign tail_pos = POS_W'(r_count);
    assign new_word = ENTRY_WIDTH'(i_in_item.entry_data);

    // Decode the operation into cell commands, next count and status.
    always_comb begin
        cell_ctrl = '0;
        n_count   = r_count;
        status    = ST_OK;
        rd_pos    = '0;
        case (i_in_item.operation)
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    cell_ctrl.shift_up   = (i_in_item.operation == OP_INS_HEAD);
                    cell_ctrl.write_tail = (i_in_item.operation == OP_INS_TAIL);
                    n_count = r_count + 1'b1;
                end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    cell_ctrl.shift_down = (i_in_item.operation == OP_REM_HEAD);
                    n_count = r_count - 1'b1;
                end
            end
            OP_RD_HEAD, OP_RD_TAIL, OP_RD_INDEX: begin
                if (i_in_item.operation == OP_RD_TAIL) begin
                    rd_pos = POS_W'(r_count - 1'b1);
                end else if (i_in_item.operation == OP_RD_INDEX) begin
                    rd_pos = POS_W'(i_in_item.element_index);
                end
                if (is_empty) begin
                    status = ST_EMPTY;
                end else if ((i_in_item.operation == OP_RD_INDEX) && (idx_ext >= cnt_ext)) begin
                    status = ST_RANGE;
                end else begin
                    cell_ctrl.read_en = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!accept) begin
            cell_ctrl = '0;
        end
    end

    // Chain of cells: each hands its word to both neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] lower_word;
        logic [ENTRY_WIDTH-1:0] upper_word;

        if (g == 0) begin : g_first
            assign lower_word = new_word;
        end else begin : g_inner_lo
            assign lower_word = cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign upper_word = '0;
        end else begin : g_inner_hi
            assign upper_word = cell_word[g+1];
        end

        bdel_cell #(
            .POS_W   (POS_W),
            .WORD_W  (ENTRY_WIDTH),
            .CELL_ID (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_tail_pos   (tail_pos),
            .i_rd_pos     (rd_pos),
            .i_new_word   (new_word),
            .i_lower_word (lower_word),
            .i_upper_word (upper_word),
            .o_word       (cell_word[g]),
            .o_rd_word    (cell_rd[g])
        );
    end

    // Collect the read bus: at most one cell drives a nonzero word.
    always_comb begin
        rd_acc = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_acc = rd_acc | cell_rd[k];
        end
    end

    // Result assembly.
    always_comb begin
        n_out_item.read_data   = 32'(rd_acc);
        n_out_item.entry_count = 7'(n_count);
        n_out_item.status      = status;
    end

    // Count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hdl/bdel_checker.sv
// ============================================================================
// Bounded double-ended list: port checker
// Watches the top level's ports and flags results that break the list's
// rules or the output handshake.
// ============================================================================
`default_nettype none

module bdel_checker
    import bdel_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // A held result stays put while the output is stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer changed while stalled");

    // The input is stalled only behind a held, stalled result.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending stalled result");

    // Any failed operation reads nothing.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> o_out_item.read_data == '0)
        else $error("failed operation returned data");

    // An empty report comes with a zero count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY) |-> o_out_item.entry_count == '0)
        else $error("empty status with nonzero count");

    // A full report comes with the count at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL)
            |-> o_out_item.entry_count == 7'(CAPACITY))
        else $error("full status with count below capacity");

endmodule

bind bounded_double_ended_list_unit bdel_checker #(.CAPACITY(CAPACITY)) u_bdel_checker (.*);

`default_nettype wire

### bench/bounded_double_ended_list_unit_tb.sv
// ============================================================================
// Bounded double-ended list unit testbench
// Drives list operations through the input channel, tracks a shadow copy of
// the list contents to work out each reply, and checks every output transfer
// field by field. Directed corner cases come first, then random bursts that
// fill, drain and exercise the list under several sender and receiver
// idling patterns.
// ============================================================================
`default_nettype none

import bdel_pkg::*;

// Shadow list that predicts the reply to every accepted operation and
// checks the replies as they come out of the block.
class list_tracker;
    localparam int unsigned LIST_DEPTH = 64;

    logic [31:0] shadow_cells [LIST_DEPTH];
    int unsigned shadow_count;
    t_out_item   awaited_results [$];
    int unsigned error_count;

    function new();
        shadow_count = 0;
        error_count  = 0;
    endfunction

    // Print one mismatch line and count it.
    task report(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function int unsigned pending();
        return awaited_results.size();
    endfunction

    // Apply one accepted operation to the shadow list and queue its reply.
    function void note_operation(input t_in_item op_item);
        t_out_item reply;
        int unsigned k;
        reply           = '0;
        reply.status    = ST_OK;
        case (op_item.operation)
            OP_INS_HEAD: begin
                if (shadow_count >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    for (k = shadow_count; k > 0; k--) begin
                        shadow_cells[k] = shadow_cells[k - 1];
                    end
                    shadow_cells[0] = op_item.entry_data;
                    shadow_count++;
                end
            end
            OP_INS_TAIL: begin
                if (shadow_count >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_cells[shadow_count] = op_item.entry_data;
                    shadow_count++;
                end
            end
            OP_REM_HEAD: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    for (k = 0; k + 1 < shadow_count; k++) begin
                        shadow_cells[k] = shadow_cells[k + 1];
                    end
                    shadow_count--;
                end
            end
            OP_REM_TAIL: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                end
            end
            OP_RD_HEAD: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.read_data = shadow_cells[0];
                end
            end
            OP_RD_TAIL: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.read_data = shadow_cells[shadow_count - 1];
                end
            end
            OP_RD_INDEX: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (op_item.element_index >= shadow_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.read_data = shadow_cells[op_item.element_index];
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        reply.entry_count = 7'(shadow_count);
        awaited_results.push_back(reply);
    endfunction

    // Compare one output transfer with the oldest queued reply.
    task check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            report($sformatf("result with nothing awaited: data=%h count=%0d status=%0d",
                             got.read_data, got.entry_count, got.status));
        end else begin
            want = awaited_results.pop_front();
            if (got.read_data !== want.read_data) begin
                report($sformatf("read_data got %h want %h", got.read_data,
                                 want.read_data));
            end
            if (got.entry_count !== want.entry_count) begin
                report($sformatf("entry_count got %0d want %0d", got.entry_count,
                                 want.entry_count));
            end
            if (got.status !== want.status) begin
                report($sformatf("status got %0d want %0d", got.status,
                                 want.status));
            end
        end
    endtask
endclass

module bounded_double_ended_list_unit_tb;

    localparam int unsigned LIST_DEPTH   = 64;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // Random burst flavors.
    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIX
    } t_burst;

    // Idle percentages per traffic phase: none, sender, receiver, both.
    int unsigned send_idle_pct [4] = '{0, 79, 0, 24};
    int unsigned recv_stall_pct [4] = '{0, 0, 79, 24};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int unsigned phase_sel = 0;
    int unsigned cycles    = 0;
    list_tracker tracker   = new();

    bounded_double_ended_list_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Clock with a period of 10.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch both channels at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tracker.note_operation(in_item);
            end
            if (out_valid && !out_stall) begin
                tracker.check_result(out_item);
            end
        end
    end

    // Receiver stalls at random according to the current phase.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct[phase_sel]);
    end

    // Guard against a hung handshake.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bounded_double_ended_list_unit_tb failed");
            $finish;
        end
    end

    function automatic t_in_item make_op(input t_op op, input logic [31:0] data,
                                         input logic [5:0] idx);
        t_in_item it;
        it.operation     = op;
        it.entry_data    = data;
        it.element_index = idx;
        return it;
    endfunction

    // Offer one transfer, with random idle cycles ahead of it, and hold it
    // until it is accepted. Called and returns at a falling edge.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct[phase_sel]) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Pick a random operation whose mix depends on the burst flavor.
    function automatic t_in_item make_random_op(input t_burst burst,
                                                input int unsigned count);
        t_in_item    it;
        int unsigned roll;
        t_op         op;
        roll = $urandom_range(99);
        if (burst == BURST_FILL && count < LIST_DEPTH) begin
            op = (roll < 45) ? OP_INS_HEAD : (roll < 90) ? OP_INS_TAIL : OP_RD_INDEX;
        end else if (burst == BURST_DRAIN) begin
            op = (roll < 40) ? OP_REM_HEAD : (roll < 80) ? OP_REM_TAIL :
                 (roll < 88) ? OP_RD_INDEX : (roll < 92) ? OP_RD_HEAD :
                 (roll < 96) ? OP_RD_TAIL : OP_INS_TAIL;
        end else begin
            op = (roll < 15) ? OP_INS_HEAD : (roll < 30) ? OP_INS_TAIL :
                 (roll < 42) ? OP_REM_HEAD : (roll < 54) ? OP_REM_TAIL :
                 (roll < 64) ? OP_RD_HEAD : (roll < 74) ? OP_RD_TAIL :
                 (roll < 97) ? OP_RD_INDEX : OP_CLEAR;
        end
        it.operation  = op;
        it.entry_data = $urandom;
        // Mostly in-range indexes, the rest anywhere in the field.
        if (count > 0 && $urandom_range(99) < 70) begin
            it.element_index = 6'($urandom_range(count - 1));
        end else begin
            it.element_index = 6'($urandom_range(63));
        end
        return it;
    endfunction

    initial begin
        t_burst      burst;
        int unsigned burst_left;
        int unsigned n;

        // Hold the synchronous reset, then release it.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty-list cases, both ends, index limits, clear.
        send_item(make_op(OP_RD_HEAD, 32'h0, 6'd0));
        send_item(make_op(OP_RD_TAIL, 32'h0, 6'd0));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd0));
        send_item(make_op(OP_REM_HEAD, 32'h0, 6'd0));
        send_item(make_op(OP_REM_TAIL, 32'h0, 6'd0));
        send_item(make_op(OP_CLEAR, 32'h0, 6'd0));
        send_item(make_op(OP_INS_TAIL, 32'hFFFF_FFFF, 6'd63));
        send_item(make_op(OP_INS_HEAD, 32'h0000_0000, 6'd0));
        send_item(make_op(OP_INS_HEAD, 32'h5A5A_5A5A, 6'd0));
        send_item(make_op(OP_INS_TAIL, 32'hA5A5_A5A5, 6'd0));
        send_item(make_op(OP_RD_HEAD, 32'h0, 6'd0));
        send_item(make_op(OP_RD_TAIL, 32'h0, 6'd0));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd2));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd3));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd4));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd63));
        send_item(make_op(OP_REM_HEAD, 32'h0, 6'd0));
        send_item(make_op(OP_RD_HEAD, 32'h0, 6'd0));
        send_item(make_op(OP_REM_TAIL, 32'h0, 6'd0));
        send_item(make_op(OP_RD_TAIL, 32'h0, 6'd0));
        send_item(make_op(OP_CLEAR, 32'h0, 6'd0));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd0));
        send_item(make_op(OP_INS_TAIL, 32'h0000_0001, 6'd0));
        send_item(make_op(OP_RD_INDEX, 32'h0, 6'd0));
        send_item(make_op(OP_REM_HEAD, 32'h0, 6'd0));

        // Random bursts across the four traffic phases; the first burst fills.
        burst      = BURST_FILL;
        burst_left = $urandom_range(90, 130);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            phase_sel = (n * 4) / RANDOM_ITEMS;
            if (burst_left == 0) begin
                case ($urandom_range(2))
                    0:       burst = BURST_FILL;
                    1:       burst = BURST_DRAIN;
                    default: burst = BURST_MIX;
                endcase
                burst_left = $urandom_range(30, 100);
            end
            burst_left--;
            send_item(make_random_op(burst, tracker.shadow_count));
        end
        in_valid <= 1'b0;

        // Let every awaited reply arrive, then a few more cycles.
        while (tracker.pending() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0) begin
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        end

        if (tracker.error_count == 0) begin
            $display("bounded_double_ended_list_unit_tb passed");
        end else begin
            $display("bounded_double_ended_list_unit_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### bounded_double_ended_list_unit.f
hdl/bdel_pkg.sv
hdl/bdel_cell.sv
hdl/bounded_double_ended_list_unit.sv
hdl/bdel_checker.sv
bench/bounded_double_ended_list_unit_tb.sv
